[rtl/core/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants for the nine-patch sample blend block
// holds register indexes, widths and the byte-scaling helper
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int unsigned MaxSourceTexels = 65536;
  localparam int unsigned AddrBits        = $clog2(MaxSourceTexels);
  localparam int unsigned CoordBits       = 12;
  localparam int unsigned DimBits         = 13;
  localparam int unsigned CfgDataBits     = 32;
  localparam int unsigned CfgIdxBits      = 3;
  localparam int unsigned DivSteps        = 13;

  typedef enum logic [CfgIdxBits-1:0] {
    RegDestWidth    = 3'd0,
    RegDestHeight   = 3'd1,
    RegSourceWidth  = 3'd2,
    RegSourceHeight = 3'd3,
    RegLayerAlpha   = 3'd4,
    RegNineEnable   = 3'd5,
    RegBandX        = 3'd6,
    RegBandY        = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad      = 1'b0,
    ModeComposite = 1'b1
  } mode_e;

  // (x + 127) / 255 for x <= 255 * 255, exact via multiply by reciprocal
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] t;
    logic [35:0] m;
    t = {1'b0, x} + 18'd127;
    m = t * 18'd257 + 36'd257;
    return m[23:16];
  endfunction

endpackage

`default_nettype wire

[rtl/core/nps_axis_div.sv]
// ----------------------------------------------------------------------------
// nps_axis_div: pipelined restoring divider for one axis map
// one quotient bit per stage, carries a side payload along
// ----------------------------------------------------------------------------
`default_nettype none

module nps_axis_div (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [24:0]                  num_i,
  input  wire logic [nps_pkg::DimBits-1:0]  den_i,
  input  wire logic [nps_pkg::DimBits-1:0]  base_i,
  input  wire logic                         bypass_i,
  output logic      [nps_pkg::DimBits-1:0]  res_o
);
  import nps_pkg::*;

  localparam int unsigned NumBits = 25;

  logic [NumBits-1:0] rem_q [DivSteps+1];
  logic [NumBits-1:0] quo_q [DivSteps+1];
  logic [DimBits-1:0] den_q [DivSteps+1];
  logic [DimBits-1:0] base_q [DivSteps+1];
  logic               byp_q [DivSteps+1];

  always_comb begin
    rem_q[0]  = num_i;
    quo_q[0]  = '0;
    den_q[0]  = den_i;
    base_q[0] = base_i;
    byp_q[0]  = bypass_i;
  end

  // quotient fits in 13 bits since num < den * 2^13 whenever used
  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    localparam int unsigned Sh = DivSteps - 1 - s;
    logic [NumBits+DimBits-1:0] dsh;
    logic                        ge;
    assign dsh = {{NumBits{1'b0}}, den_q[s]} << Sh;
    assign ge  = {{DimBits{1'b0}}, rem_q[s]} >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? rem_q[s] - dsh[NumBits-1:0] : rem_q[s];
        quo_q[s+1]  <= {quo_q[s][NumBits-2:0], ge};
        den_q[s+1]  <= den_q[s];
        base_q[s+1] <= base_q[s];
        byp_q[s+1]  <= byp_q[s];
      end
    end
  end

  assign res_o = byp_q[DivSteps] ? base_q[DivSteps]
                                 : base_q[DivSteps] + quo_q[DivSteps][DimBits-1:0];

endmodule

`default_nettype wire

[rtl/core/nine_patch_sample_blend.sv]
// ----------------------------------------------------------------------------
// nine_patch_sample_blend: scaled or nine-patch texture sample and blend
//
// s_axis carries input words: mode in tuser, the rest packed in tdata.
// mode load writes one texel into the 64k x 32 texel memory and gives no
// result; the write travels down the pipe before it lands in memory,
// so it stays in order with the texel reads of composite words.
// mode composite maps pos_x/pos_y to a source texel, reads it and
// returns a source-over blend of it onto dest_rgba on m_axis.
// one word is taken per cycle unless the output stalls; the path to m_axis
// valid runs through the 13-stage axis divider, the memory read and blend
// multiplier stages. the whole pipe advances when the output register is
// empty or taken, so a stalled receiver holds every stage and loses nothing.
// reset clears valid bits and registers to their reset values; the texel
// memory is not cleared. the user writes configuration through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module nine_patch_sample_blend (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [nps_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [nps_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // texel_index, texel_rgba, pos_x, pos_y, dest_rgba
  input  wire logic [103:0]                     s_axis_tdata_i,
  // mode
  input  wire logic                             s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // blended_rgba, sample_index
  output logic [47:0]                           m_axis_tdata_o
);
  import nps_pkg::*;

  localparam int unsigned NStg  = DivSteps + 6;
  localparam int unsigned LdStg = DivSteps + 2;

  logic [DimBits-1:0] dw_q, dh_q, sw_q, sh_q;
  logic [7:0]         la_q;
  logic               nine_q;
  logic [31:0]        bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= 13'd1; dh_q <= 13'd1; sw_q <= 13'd1; sh_q <= 13'd1;
      la_q <= 8'd255; nine_q <= 1'b0; bx_q <= '0; by_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegDestWidth:    dw_q   <= cfg_data_i[DimBits-1:0];
        RegDestHeight:   dh_q   <= cfg_data_i[DimBits-1:0];
        RegSourceWidth:  sw_q   <= cfg_data_i[DimBits-1:0];
        RegSourceHeight: sh_q   <= cfg_data_i[DimBits-1:0];
        RegLayerAlpha:   la_q   <= cfg_data_i[7:0];
        RegNineEnable:   nine_q <= cfg_data_i[0];
        RegBandX:        bx_q   <= cfg_data_i;
        RegBandY:        by_q   <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  logic adv;
  logic [NStg-1:0] vld_q;
  logic [LdStg-1:0] lvld_q;
  logic out_vld_q;
  assign adv = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  logic in_acc;
  logic in_load;
  assign in_acc  = s_axis_tvalid_i && adv;
  assign in_load = mode_e'(s_axis_tuser_i) == ModeLoad;

  logic [15:0] in_tidx;
  logic [31:0] in_trgba, in_drgba;
  logic [CoordBits-1:0] in_px, in_py;
  assign in_tidx  = s_axis_tdata_i[15:0];
  assign in_trgba = s_axis_tdata_i[47:16];
  assign in_px    = s_axis_tdata_i[59:48];
  assign in_py    = s_axis_tdata_i[71:60];
  assign in_drgba = s_axis_tdata_i[103:72];

  // load words carry their texel in the dest word pipe
  logic [31:0] drgba_q [NStg];
  logic [AddrBits-1:0] lidx_q [LdStg];

  logic [31:0] mem [MaxSourceTexels];
  always_ff @(posedge clk_i) begin
    if (adv && lvld_q[LdStg-1]) begin
      mem[lidx_q[LdStg-1]] <= drgba_q[LdStg-1];
    end
  end

  // stage 0: clamp and pick the map segment per axis
  typedef struct packed {
    logic [24:0]        num;
    logic [DimBits-1:0] den;
    logic [DimBits-1:0] base;
    logic               byp;
  } seg_t;

  function automatic seg_t seg(input logic [CoordBits-1:0] pos,
                               input logic [DimBits-1:0] dreg,
                               input logic [DimBits-1:0] sreg,
                               input logic [31:0] band, input logic nine);
    logic [DimBits-1:0] d, s, p, tr, mid;
    logic [15:0] lo, hi;
    logic [14:0] m;
    seg_t r;
    d  = (dreg == '0) ? 13'd1 : dreg;
    s  = (sreg == '0) ? 13'd1 : sreg;
    p  = ({1'b0, pos} >= d) ? d - 13'd1 : {1'b0, pos};
    lo = band[15:0];
    hi = band[31:16];
    tr = s - hi[DimBits-1:0];
    r.byp = 1'b0;
    if (!nine || hi <= lo || hi > {3'b0, s}) begin
      r.num = 25'(p) * 25'(s); r.den = d; r.base = '0;
    end else if ({3'b0, p} < lo) begin
      r.num = '0; r.den = 13'd1; r.base = p; r.byp = 1'b1;
    end else if (d < tr || {1'b0, p} >= {1'b0, d} - {1'b0, tr}) begin
      r.num = '0; r.den = 13'd1; r.base = s - (d - p); r.byp = 1'b1;
    end else begin
      m = {2'b0, d} - {2'b0, lo[DimBits-1:0]} - {2'b0, tr};
      mid = (m[14] || m == '0) ? 13'd1 : m[DimBits-1:0];
      r.num = 25'(p - lo[DimBits-1:0]) * 25'(hi[DimBits-1:0] - lo[DimBits-1:0]);
      r.den = mid; r.base = lo[DimBits-1:0];
    end
    return r;
  endfunction

  seg_t sx_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= seg(in_px, dw_q, sw_q, bx_q, nine_q);
      sy_q <= seg(in_py, dh_q, sh_q, by_q, nine_q);
      drgba_q[0] <= in_load ? in_trgba : in_drgba;
      for (int i = 1; i < NStg; i++) drgba_q[i] <= drgba_q[i-1];
      lidx_q[0] <= in_tidx[AddrBits-1:0];
      for (int i = 1; i < LdStg; i++) lidx_q[i] <= lidx_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      lvld_q <= '0;
    end else if (adv) begin
      vld_q  <= {vld_q[NStg-2:0], in_acc && !in_load};
      lvld_q <= {lvld_q[LdStg-2:0], in_acc && in_load};
    end
  end

  logic [DimBits-1:0] mx, my;
  nps_axis_div u_div_x (.clk_i, .en_i(adv), .num_i(sx_q.num), .den_i(sx_q.den),
                        .base_i(sx_q.base), .bypass_i(sx_q.byp), .res_o(mx));
  nps_axis_div u_div_y (.clk_i, .en_i(adv), .num_i(sy_q.num), .den_i(sy_q.den),
                        .base_i(sy_q.base), .bypass_i(sy_q.byp), .res_o(my));

  // stage 14: address multiply
  localparam int unsigned S = DivSteps + 1;
  logic [25:0] addr_q;
  logic [31:0] tex_q;
  logic        inr_q;
  logic [15:0] sidx_q, sidx2_q, sidx3_q, sidx4_q;
  logic [DimBits-1:0] swn;
  assign swn = (sw_q == '0) ? 13'd1 : sw_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      addr_q  <= 26'(my) * 26'(swn) + 26'(mx);
      tex_q   <= mem[addr_q[AddrBits-1:0]];
      inr_q   <= addr_q < 26'(MaxSourceTexels);
      sidx_q  <= addr_q[15:0];
      sidx2_q <= sidx_q;
      sidx3_q <= sidx2_q;
      sidx4_q <= sidx3_q;
    end
  end

  // blend stages
  logic [31:0] t2_q;
  logic [15:0] sap_q;
  logic [7:0]  sa_q, sa2_q;
  logic [31:0] t3_q;
  logic [16:0] pr_q, pg_q, pb_q, pa_q;
  logic [7:0]  inv;
  logic [31:0] dp;
  assign inv = 8'd255 - sa_q;
  assign dp  = drgba_q[S+3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_q  <= inr_q ? tex_q : '0;
      sap_q <= 16'((inr_q ? tex_q[7:0] : 8'd0)) * 16'(la_q);
      t3_q  <= t2_q;
      sa_q  <= div255({1'b0, sap_q});
      sa2_q <= sa_q;
      pr_q  <= 17'(t3_q[31:24]) * 17'(sa_q) + 17'(dp[31:24]) * 17'(inv);
      pg_q  <= 17'(t3_q[23:16]) * 17'(sa_q) + 17'(dp[23:16]) * 17'(inv);
      pb_q  <= 17'(t3_q[15:8])  * 17'(sa_q) + 17'(dp[15:8])  * 17'(inv);
      pa_q  <= 17'(dp[7:0]) * 17'(inv);
    end
  end

  logic [47:0] out_q;
  logic [7:0]  a_sum;
  assign a_sum = sa2_q + div255(pa_q);
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {sidx4_q, div255(pr_q), div255(pg_q), div255(pb_q), a_sum};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld_q[NStg-1];
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> out_vld_q && $stable(out_q)) else $error("output lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o) else $error("stall without full output");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("pipe moved while stalled");

endmodule

`default_nettype wire
